@@ src/pabg_pkg.sv @@
// Shared types, constants and helpers of the pixel alpha blend and gamma unit.
package pabg_pkg;

  localparam int CH_W      = 8;   // one color channel or alpha
  localparam int COORD_W   = 11;  // signed pixel coordinate
  localparam int IDX_W     = 18;  // pixel index on the result port
  localparam int SUM_W     = 16;  // a*c + (255-a)*o, at most 65025
  localparam int ROOT_BITS = 8;   // root of SUM_W bits, one cell per bit
  localparam int NUM_CH    = 3;   // red, green, blue
  localparam int DIM_W     = COORD_W - 1;
  localparam int DEF_WIDTH  = 512;
  localparam int DEF_HEIGHT = 512;

  localparam logic GAMMA_RESET = 1'b1;

  typedef logic [CH_W-1:0] chan_t;

  // One accepted input beat.
  typedef struct packed {
    logic [COORD_W-1:0]           pos_x;
    logic [COORD_W-1:0]           pos_y;
    logic [NUM_CH-1:0][CH_W-1:0]  src;
    logic [CH_W-1:0]              opacity;
    logic [NUM_CH-1:0][CH_W-1:0]  old;
  } pix_t;

  // Per-item control carried alongside the channel lanes.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] index;
    logic             gamma;
  } side_t;

  // Data that one channel hands from cell to cell.
  typedef struct packed {
    logic [SUM_W-1:0]     rem;
    logic [ROOT_BITS-1:0] root;
    logic [CH_W-1:0]      lin;
  } lane_t;

  // floor(s / 255) for s below 65280, by the add-and-shift identity.
  function automatic logic [CH_W-1:0] div255(input logic [SUM_W-1:0] s);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W+1)'(1) + (SUM_W+1)'(s[SUM_W-1:CH_W]);
    return t[SUM_W-1:CH_W];
  endfunction

endpackage

@@ src/pixel_alpha_blend_gamma_unit.sv @@
// Top level of the pixel alpha blend unit with linear and square-root gamma modes.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+--------------------------------------------------
//  input    | start / busy         | in_pos_x, in_pos_y, in_src_*, in_opacity, in_old_*
//  result   | out_strobe           | out_write_enable, out_pixel_index, out_new_*
//  config   | cfg_valid/cfg_ready  | cfg_gamma_mode
//
// One beat is accepted every clock while start is high and busy is low; each
// beat passes two front stages (input register, then the blend multiply-add),
// eight square-root cells, one per root bit, and the output register, and then
// appears as a result on out_strobe.
// Reset is synchronous and active low; during reset busy is high, cfg_ready is low,
// and gamma_mode returns to the square-root setting.
// The receiver cannot stall, so no beat is ever held back inside the pipeline.
module pixel_alpha_blend_gamma_unit #(
  parameter int WIDTH  = pabg_pkg::DEF_WIDTH,
  parameter int HEIGHT = pabg_pkg::DEF_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel.
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [pabg_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [pabg_pkg::COORD_W-1:0]  in_pos_y,
  input  logic [pabg_pkg::CH_W-1:0]            in_src_red,
  input  logic [pabg_pkg::CH_W-1:0]            in_src_green,
  input  logic [pabg_pkg::CH_W-1:0]            in_src_blue,
  input  logic [pabg_pkg::CH_W-1:0]            in_opacity,
  input  logic [pabg_pkg::CH_W-1:0]            in_old_red,
  input  logic [pabg_pkg::CH_W-1:0]            in_old_green,
  input  logic [pabg_pkg::CH_W-1:0]            in_old_blue,
  // Result channel.
  output logic                                 out_strobe,
  output logic                                 out_write_enable,
  output logic [pabg_pkg::IDX_W-1:0]           out_pixel_index,
  output logic [pabg_pkg::CH_W-1:0]            out_new_red,
  output logic [pabg_pkg::CH_W-1:0]            out_new_green,
  output logic [pabg_pkg::CH_W-1:0]            out_new_blue,
  // Configuration channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_gamma_mode
);

  localparam int CELLS   = pabg_pkg::ROOT_BITS;
  localparam int NCH     = pabg_pkg::NUM_CH;
  localparam int LATENCY = CELLS + 3;

  // The block never pushes back except while it is held in reset.
  logic accept;
  assign busy      = !rst_n;
  assign cfg_ready = rst_n;
  assign accept    = start && !busy;

  // Mode register. It is to be written only while the pipeline is empty, a rule on the user
  // that the block does not enforce; each beat still carries the mode it was accepted under.
  logic gamma_mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_mode_r <= pabg_pkg::GAMMA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gamma_mode_r <= cfg_gamma_mode;
    end
  end

  pabg_pkg::pix_t pix;
  always_comb begin
    pix.pos_x   = in_pos_x;
    pix.pos_y   = in_pos_y;
    pix.src     = {in_src_blue, in_src_green, in_src_red};
    pix.opacity = in_opacity;
    pix.old     = {in_old_blue, in_old_green, in_old_red};
  end

  // Front end: frame test, index and the blend sum S = a*c + (255-a)*o per channel.
  logic                                         front_valid;
  pabg_pkg::side_t                              front_side;
  logic [NCH-1:0][pabg_pkg::SUM_W-1:0]          front_sum;

  pabg_front #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .pix     (pix),
    .gamma   (gamma_mode_r),
    .valid_r (front_valid),
    .side_r  (front_side),
    .sum_r   (front_sum)
  );

  // Cell chain. lane[ch][k] feeds cell k; cell k decides root bit CELLS-1-k.
  // The linear quotient is formed once at the chain entry and rides along.
  pabg_pkg::lane_t lane [NCH][CELLS+1];

  for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
    always_comb begin
      lane[ch][0].rem  = front_sum[ch];
      lane[ch][0].root = '0;
      lane[ch][0].lin  = pabg_pkg::div255(front_sum[ch]);
    end
    for (genvar k = 0; k < CELLS; k++) begin : g_cell
      pabg_sqrt_cell #(
        .BIT (CELLS - 1 - k)
      ) u_cell (
        .clk     (clk),
        .lane_in (lane[ch][k]),
        .lane_r  (lane[ch][k+1])
      );
    end
  end

  // Valid bits and per-item control travel in step with the cells.
  logic [CELLS-1:0] chain_valid_r;
  pabg_pkg::side_t  chain_side_r [CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_valid_r <= '0;
    end else begin
      chain_valid_r <= {chain_valid_r[CELLS-2:0], front_valid};
    end
    chain_side_r[0] <= front_side;
    for (int k = 1; k < CELLS; k++) begin
      chain_side_r[k] <= chain_side_r[k-1];
    end
  end

  // Output register: pick the root or the linear quotient, zero everything off-frame.
  pabg_pkg::side_t last_side;
  pabg_pkg::chan_t new_nxt [NCH];
  pabg_pkg::chan_t new_r   [NCH];
  logic            we_r;
  logic [pabg_pkg::IDX_W-1:0] index_r;
  logic            strobe_r;

  assign last_side = chain_side_r[CELLS-1];

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      if (!last_side.we) begin
        new_nxt[ch] = '0;
      end else if (last_side.gamma) begin
        new_nxt[ch] = lane[ch][CELLS].root;
      end else begin
        new_nxt[ch] = lane[ch][CELLS].lin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= chain_valid_r[CELLS-1];
    end
    we_r    <= last_side.we;
    index_r <= last_side.we ? last_side.index : '0;
    for (int ch = 0; ch < NCH; ch++) begin
      new_r[ch] <= new_nxt[ch];
    end
  end

  assign out_strobe       = strobe_r;
  assign out_write_enable = we_r;
  assign out_pixel_index  = index_r;
  assign out_new_red      = new_r[0];
  assign out_new_green    = new_r[1];
  assign out_new_blue     = new_r[2];

  // Every result strobe goes back to an accepted beat.
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LATENCY))
    else $error("result strobe without an accepted beat");

  // Every accepted beat leaves the pipeline as a result strobe.
  a_strobe_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept, LATENCY) |-> out_strobe)
    else $error("accepted beat did not produce a result strobe");

  // A suppressed write carries an all-zero payload.
  a_offframe_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_write_enable |->
      out_pixel_index == '0 && out_new_red == '0 && out_new_green == '0 &&
      out_new_blue == '0)
    else $error("off-frame result has nonzero payload");

  // The write enable reflects the frame test on the coordinates of the matching beat.
  a_frame_test: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_write_enable ==
      ($past(in_pos_x, LATENCY) >= 0 && $past(in_pos_x, LATENCY) < WIDTH &&
       $past(in_pos_y, LATENCY) >= 0 && $past(in_pos_y, LATENCY) < HEIGHT))
    else $error("write enable disagrees with frame test");

endmodule

@@ src/pabg_front.sv @@
// Front end: input register, frame test, pixel index and per-channel blend sums.
module pabg_front #(
  parameter int WIDTH  = pabg_pkg::DEF_WIDTH,
  parameter int HEIGHT = pabg_pkg::DEF_HEIGHT
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      accept,
  input  pabg_pkg::pix_t                            pix,
  input  logic                                      gamma,
  output logic                                      valid_r,
  output pabg_pkg::side_t                           side_r,
  output logic [pabg_pkg::NUM_CH-1:0][pabg_pkg::SUM_W-1:0] sum_r
);

  localparam int DW = pabg_pkg::DIM_W;
  localparam int PW = 2 * DW;
  localparam logic [DW-1:0] WIDTH_V  = DW'(WIDTH);
  localparam logic [DW-1:0] HEIGHT_V = DW'(HEIGHT);

  logic            v1_r;
  pabg_pkg::pix_t  pix1_r;
  pabg_pkg::side_t side1_r;
  pabg_pkg::side_t side1_nxt;
  logic [PW-1:0]   idx_full;
  logic [pabg_pkg::NUM_CH-1:0][pabg_pkg::SUM_W-1:0] sum_nxt;
  logic [pabg_pkg::SUM_W-1:0] alpha_w;
  logic [pabg_pkg::SUM_W-1:0] inv_w;

  always_comb begin
    idx_full = PW'(pix.pos_x[DW-1:0]) + PW'(pix.pos_y[DW-1:0]) * PW'(WIDTH_V);
    side1_nxt.we = !pix.pos_x[pabg_pkg::COORD_W-1] && !pix.pos_y[pabg_pkg::COORD_W-1] &&
                   (pix.pos_x[DW-1:0] < WIDTH_V) && (pix.pos_y[DW-1:0] < HEIGHT_V);
    side1_nxt.index = side1_nxt.we ? idx_full[pabg_pkg::IDX_W-1:0] : '0;
    side1_nxt.gamma = gamma;
  end

  always_comb begin
    alpha_w = pabg_pkg::SUM_W'(pix1_r.opacity);
    inv_w   = pabg_pkg::SUM_W'(8'd255 - pix1_r.opacity);
    for (int ch = 0; ch < pabg_pkg::NUM_CH; ch++) begin
      sum_nxt[ch] = alpha_w * pabg_pkg::SUM_W'(pix1_r.src[ch]) +
                    inv_w * pabg_pkg::SUM_W'(pix1_r.old[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      v1_r    <= accept;
      valid_r <= v1_r;
    end
    pix1_r  <= pix;
    side1_r <= side1_nxt;
    side_r  <= side1_r;
    sum_r   <= sum_nxt;
  end

endmodule

@@ src/pabg_sqrt_cell.sv @@
// One square-root cell: decides a single root bit of one channel and passes the lane on.
module pabg_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic            clk,
  input  pabg_pkg::lane_t lane_in,
  output pabg_pkg::lane_t lane_r
);

  localparam int TW = pabg_pkg::SUM_W + 1;

  logic [TW-1:0]   trial;
  pabg_pkg::lane_t lane_nxt;

  // With rem = S - root^2, setting this bit costs 2*root*2^BIT + 4^BIT.
  always_comb begin
    trial    = (TW'(lane_in.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    lane_nxt = lane_in;
    if ({1'b0, lane_in.rem} >= trial) begin
      lane_nxt.rem       = lane_in.rem - trial[pabg_pkg::SUM_W-1:0];
      lane_nxt.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

endmodule
